[design/irs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the image resize sampler.
// No dependencies; every other design file refers to this package.
package irs_pkg;

	localparam int COORD_W    = 12;
	localparam int PLANE_W    = 2;
	localparam int SAMPLE_W   = 8;
	localparam int SRC_CFG_W  = 9;
	localparam int TGT_CFG_W  = 13;
	localparam int FRAC_W     = 16;
	localparam int TARGET_MAX = 4096;

	localparam int DEF_MAX_SRC_WIDTH  = 256;
	localparam int DEF_MAX_SRC_HEIGHT = 256;
	localparam int DEF_MAX_PLANES     = 4;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH  = 3'd2,
		REG_TARGET_HEIGHT = 3'd3,
		REG_INTERP_MODE   = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic {
		MODE_NEAREST  = 1'b0,
		MODE_BILINEAR = 1'b1
	} interp_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [COORD_W-1:0]    column;
		logic [COORD_W-1:0]    row;
		logic [PLANE_W-1:0]    plane;
		logic [SAMPLE_W-1:0]   sample_in;
	} req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic                range_error;
	} rsp_t;

	typedef struct packed {
		logic [SRC_CFG_W-1:0] src_w;
		logic [SRC_CFG_W-1:0] src_h;
		logic [TGT_CFG_W-1:0] tgt_w;
		logic [TGT_CFG_W-1:0] tgt_h;
		interp_t              mode;
	} cfg_t;

	typedef struct packed {
		opcode_t             opcode;
		logic                range_error;
		logic [COORD_W-1:0]  column;
		logic [COORD_W-1:0]  row;
		logic [PLANE_W-1:0]  plane;
		logic [SAMPLE_W-1:0] sample;
	} tag_t;

endpackage

[design/irs_ifs.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the image resize sampler.
// Depends on irs_pkg for the payload types.
interface irs_req_if;
	logic          valid;
	logic          ready;
	irs_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface irs_rsp_if;
	logic          valid;
	logic          ready;
	irs_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[design/irs_cfg_regs.sv]
`timescale 1ns / 1ps
// APB register file holding the image sizes and the interpolation mode.
// Depends on irs_pkg; delivers the saturated sizes as one struct.
module irs_cfg_regs #(
	parameter int MAX_SRC_WIDTH  = irs_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = irs_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [irs_pkg::PADDR_W-1:0]  paddr,
	input  logic [irs_pkg::PDATA_W-1:0]  pwdata,
	output logic [irs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output irs_pkg::cfg_t                cfg
);

	logic [irs_pkg::SRC_CFG_W-1:0] src_w_q;
	logic [irs_pkg::SRC_CFG_W-1:0] src_h_q;
	logic [irs_pkg::TGT_CFG_W-1:0] tgt_w_q;
	logic [irs_pkg::TGT_CFG_W-1:0] tgt_h_q;
	irs_pkg::interp_t              mode_q;
	irs_pkg::reg_idx_t             idx;
	logic                          wr;

	assign idx    = irs_pkg::reg_idx_t'(paddr[irs_pkg::PADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= irs_pkg::SRC_CFG_W'(256);
			src_h_q <= irs_pkg::SRC_CFG_W'(256);
			tgt_w_q <= irs_pkg::TGT_CFG_W'(256);
			tgt_h_q <= irs_pkg::TGT_CFG_W'(256);
			mode_q  <= irs_pkg::MODE_BILINEAR;
		end else if (wr) begin
			unique case (idx)
				irs_pkg::REG_SOURCE_WIDTH:  src_w_q <= pwdata[irs_pkg::SRC_CFG_W-1:0];
				irs_pkg::REG_SOURCE_HEIGHT: src_h_q <= pwdata[irs_pkg::SRC_CFG_W-1:0];
				irs_pkg::REG_TARGET_WIDTH:  tgt_w_q <= pwdata[irs_pkg::TGT_CFG_W-1:0];
				irs_pkg::REG_TARGET_HEIGHT: tgt_h_q <= pwdata[irs_pkg::TGT_CFG_W-1:0];
				irs_pkg::REG_INTERP_MODE:   mode_q  <= irs_pkg::interp_t'(pwdata[0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			irs_pkg::REG_SOURCE_WIDTH:  prdata = irs_pkg::PDATA_W'(src_w_q);
			irs_pkg::REG_SOURCE_HEIGHT: prdata = irs_pkg::PDATA_W'(src_h_q);
			irs_pkg::REG_TARGET_WIDTH:  prdata = irs_pkg::PDATA_W'(tgt_w_q);
			irs_pkg::REG_TARGET_HEIGHT: prdata = irs_pkg::PDATA_W'(tgt_h_q);
			irs_pkg::REG_INTERP_MODE:   prdata = irs_pkg::PDATA_W'(mode_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode = mode_q;
		if (src_w_q == '0) begin
			cfg.src_w = irs_pkg::SRC_CFG_W'(1);
		end else if (32'(src_w_q) > MAX_SRC_WIDTH) begin
			cfg.src_w = irs_pkg::SRC_CFG_W'(MAX_SRC_WIDTH);
		end else begin
			cfg.src_w = src_w_q;
		end
		if (src_h_q == '0) begin
			cfg.src_h = irs_pkg::SRC_CFG_W'(1);
		end else if (32'(src_h_q) > MAX_SRC_HEIGHT) begin
			cfg.src_h = irs_pkg::SRC_CFG_W'(MAX_SRC_HEIGHT);
		end else begin
			cfg.src_h = src_h_q;
		end
		if (tgt_w_q == '0) begin
			cfg.tgt_w = irs_pkg::TGT_CFG_W'(1);
		end else if (32'(tgt_w_q) > irs_pkg::TARGET_MAX) begin
			cfg.tgt_w = irs_pkg::TGT_CFG_W'(irs_pkg::TARGET_MAX);
		end else begin
			cfg.tgt_w = tgt_w_q;
		end
		if (tgt_h_q == '0) begin
			cfg.tgt_h = irs_pkg::TGT_CFG_W'(1);
		end else if (32'(tgt_h_q) > irs_pkg::TARGET_MAX) begin
			cfg.tgt_h = irs_pkg::TGT_CFG_W'(irs_pkg::TARGET_MAX);
		end else begin
			cfg.tgt_h = tgt_h_q;
		end
	end

endmodule

[design/irs_coord_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider for both source coordinates, one quotient bit per stage.
// Depends on irs_pkg; carries the request tag alongside the quotients.
module irs_coord_div #(
	parameter int QN = 24,
	parameter int NW = 37
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  irs_pkg::tag_t                 in_tag,
	input  logic [NW-1:0]                 num_x,
	input  logic [NW-1:0]                 num_y,
	input  logic [irs_pkg::TGT_CFG_W-1:0] den_x,
	input  logic [irs_pkg::TGT_CFG_W-1:0] den_y,
	output logic                          out_valid,
	output irs_pkg::tag_t                 out_tag,
	output logic [QN-1:0]                 quo_x,
	output logic [QN-1:0]                 quo_y
);

	localparam int RW = irs_pkg::TGT_CFG_W;

	logic          v_s   [QN];
	irs_pkg::tag_t tag_s [QN];
	logic [RW-1:0] rx_s  [QN];
	logic [RW-1:0] ry_s  [QN];
	logic [QN-1:0] wx_s  [QN];
	logic [QN-1:0] wy_s  [QN];

	function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic nbit,
		logic [RW-1:0] den);
		logic [RW:0] trial;
		trial = {rem, nbit};
		if (trial >= {1'b0, den}) begin
			return {1'b1, RW'(trial - {1'b0, den})};
		end
		return {1'b0, trial[RW-1:0]};
	endfunction

	for (genvar k = 0; k < QN; k++) begin : g_stage
		logic          cur_v;
		irs_pkg::tag_t cur_tag;
		logic [RW-1:0] cur_rx, cur_ry;
		logic [QN-1:0] cur_wx, cur_wy;
		logic [RW:0]   sx, sy;

		if (k == 0) begin : g_first
			assign cur_v   = in_valid;
			assign cur_tag = in_tag;
			assign cur_rx  = RW'(num_x >> QN);
			assign cur_ry  = RW'(num_y >> QN);
			assign cur_wx  = num_x[QN-1:0];
			assign cur_wy  = num_y[QN-1:0];
		end else begin : g_next
			assign cur_v   = v_s[k-1];
			assign cur_tag = tag_s[k-1];
			assign cur_rx  = rx_s[k-1];
			assign cur_ry  = ry_s[k-1];
			assign cur_wx  = wx_s[k-1];
			assign cur_wy  = wy_s[k-1];
		end

		assign sx = div_step(cur_rx, cur_wx[QN-1], den_x);
		assign sy = div_step(cur_ry, cur_wy[QN-1], den_y);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= cur_tag;
				rx_s[k]  <= sx[RW-1:0];
				ry_s[k]  <= sy[RW-1:0];
				wx_s[k]  <= {cur_wx[QN-2:0], sx[RW]};
				wy_s[k]  <= {cur_wy[QN-2:0], sy[RW]};
			end
		end
	end

	assign out_valid = v_s[QN-1];
	assign out_tag   = tag_s[QN-1];
	assign quo_x     = wx_s[QN-1];
	assign quo_y     = wy_s[QN-1];

endmodule

[design/irs_sample_store.sv]
`timescale 1ns / 1ps
// Source sample store in four banks split by row and column parity, four reads a cycle while en is high.
// Depends on irs_pkg; read data is registered and steered to the four neighbours.
module irs_sample_store #(
	parameter int MAX_SRC_WIDTH  = irs_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = irs_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int MAX_PLANES     = irs_pkg::DEF_MAX_PLANES,
	parameter int CXW            = 8,
	parameter int CYW            = 8
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         wr_en,
	input  logic [CXW-1:0]               wr_x,
	input  logic [CYW-1:0]               wr_y,
	input  logic [irs_pkg::PLANE_W-1:0]  wr_plane,
	input  logic [irs_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [CXW-1:0]               rd_x_lo,
	input  logic [CXW-1:0]               rd_x_hi,
	input  logic [CYW-1:0]               rd_y_lo,
	input  logic [CYW-1:0]               rd_y_hi,
	input  logic [irs_pkg::PLANE_W-1:0]  rd_plane,
	output logic [irs_pkg::SAMPLE_W-1:0] v00,
	output logic [irs_pkg::SAMPLE_W-1:0] v10,
	output logic [irs_pkg::SAMPLE_W-1:0] v01,
	output logic [irs_pkg::SAMPLE_W-1:0] v11
);

	localparam int HC         = (MAX_SRC_WIDTH + 1) / 2;
	localparam int HR         = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int XHW        = (HC > 1) ? $clog2(HC) : 1;
	localparam int YHW        = (HR > 1) ? $clog2(HR) : 1;
	localparam int BANK_DEPTH = MAX_PLANES * (1 << (XHW + YHW));
	localparam int AW         = $clog2(BANK_DEPTH);

	logic [irs_pkg::SAMPLE_W-1:0] bank_rd [2][2];
	logic xlo_par_q, xhi_par_q, ylo_par_q, yhi_par_q;
	logic [AW-1:0] wr_addr;

	assign wr_addr = AW'({wr_plane, YHW'(wr_y >> 1), XHW'(wr_x >> 1)});

	always_ff @(posedge clk) begin
		if (en) begin
			xlo_par_q <= rd_x_lo[0];
			xhi_par_q <= rd_x_hi[0];
			ylo_par_q <= rd_y_lo[0];
			yhi_par_q <= rd_y_hi[0];
		end
	end

	for (genvar by = 0; by < 2; by++) begin : g_row
		for (genvar bx = 0; bx < 2; bx++) begin : g_col
			logic [irs_pkg::SAMPLE_W-1:0] mem [BANK_DEPTH];
			logic [irs_pkg::SAMPLE_W-1:0] rd_q;
			logic [CXW-1:0] sel_x;
			logic [CYW-1:0] sel_y;
			logic [AW-1:0]  rd_addr;
			logic           bank_we;

			assign sel_x   = (rd_x_lo[0] == 1'(bx)) ? rd_x_lo : rd_x_hi;
			assign sel_y   = (rd_y_lo[0] == 1'(by)) ? rd_y_lo : rd_y_hi;
			assign rd_addr = AW'({rd_plane, YHW'(sel_y >> 1), XHW'(sel_x >> 1)});
			assign bank_we = wr_en && (wr_y[0] == 1'(by)) && (wr_x[0] == 1'(bx));

			always_ff @(posedge clk) begin
				if (bank_we) begin
					mem[wr_addr] <= wr_data;
				end
				if (en) begin
					rd_q <= mem[rd_addr];
				end
			end

			assign bank_rd[by][bx] = rd_q;
		end
	end

	assign v00 = bank_rd[ylo_par_q][xlo_par_q];
	assign v10 = bank_rd[ylo_par_q][xhi_par_q];
	assign v01 = bank_rd[yhi_par_q][xlo_par_q];
	assign v11 = bank_rd[yhi_par_q][xhi_par_q];

endmodule

[design/irs_blend.sv]
`timescale 1ns / 1ps
// Three-stage bilinear blend: horizontal products, vertical products, sum, rounding and clamp.
// Depends on irs_pkg for the response type.
module irs_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic                         in_zero,
	input  logic                         in_err,
	input  logic [irs_pkg::SAMPLE_W-1:0] v00,
	input  logic [irs_pkg::SAMPLE_W-1:0] v10,
	input  logic [irs_pkg::SAMPLE_W-1:0] v01,
	input  logic [irs_pkg::SAMPLE_W-1:0] v11,
	input  logic [irs_pkg::FRAC_W-1:0]   fx,
	input  logic [irs_pkg::FRAC_W-1:0]   fy,
	output logic                         out_valid,
	output irs_pkg::rsp_t                out_rsp
);

	localparam int WW = irs_pkg::FRAC_W + 1;
	localparam int HW = WW + irs_pkg::SAMPLE_W + 1;
	localparam int PW = WW + HW;
	localparam int AW = PW + 1;
	localparam int RW = AW - 2 * irs_pkg::FRAC_W;

	logic [WW-1:0] gx, gy_in;
	logic [HW-1:0] h0, h1;
	logic [AW-1:0] acc;
	logic [RW-1:0] rnd;

	logic          v_s1, v_s2, v_s3;
	logic          zero_s1, zero_s2;
	logic          err_s1, err_s2;
	logic [HW-1:0] h0_s1, h1_s1;
	logic [WW-1:0] gy_s1, fy_s1;
	logic [PW-1:0] p0_s2, p1_s2;
	irs_pkg::rsp_t rsp_s3;

	assign gx    = WW'(1 << irs_pkg::FRAC_W) - WW'(fx);
	assign gy_in = WW'(1 << irs_pkg::FRAC_W) - WW'(fy);
	assign h0    = HW'(gx) * HW'(v00) + HW'(fx) * HW'(v10);
	assign h1    = HW'(gx) * HW'(v01) + HW'(fx) * HW'(v11);
	assign acc   = AW'(p0_s2) + AW'(p1_s2) + AW'(64'd1 << (2 * irs_pkg::FRAC_W - 1));
	assign rnd   = acc[AW-1:2*irs_pkg::FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= in_zero;
			err_s1  <= in_err;
			h0_s1   <= h0;
			h1_s1   <= h1;
			gy_s1   <= gy_in;
			fy_s1   <= WW'(fy);
			zero_s2 <= zero_s1;
			err_s2  <= err_s1;
			p0_s2   <= PW'(gy_s1) * PW'(h0_s1);
			p1_s2   <= PW'(fy_s1) * PW'(h1_s1);
			rsp_s3.range_error <= err_s2;
			if (zero_s2) begin
				rsp_s3.sample_out <= '0;
			end else if (rnd > RW'(255)) begin
				rsp_s3.sample_out <= 8'hFF;
			end else begin
				rsp_s3.sample_out <= rnd[irs_pkg::SAMPLE_W-1:0];
			end
		end
	end

	assign out_valid = v_s3;
	assign out_rsp   = rsp_s3;

endmodule

[design/image_resize_sampler_unit.sv]
`timescale 1ns / 1ps
// Top level of the image resize sampler: register file, coordinate divider,
// banked sample store, blend pipeline and a two-entry output buffer. Uses irs_pkg and irs_ifs.
//
//   Channel   Role     Handshake        Payload
//   req       sink     valid / ready    opcode, column, row, plane, sample_in
//   rsp       source   valid / ready    sample_out, range_error
//   apb       slave    psel / penable   sizes and interpolation mode
//
// One request enters every cycle while the skid register is empty. It passes input and product
// registers, Q divider stages (Q is log2 of the larger source size plus 16), coordinate and
// store read registers, blend stages and the output register. Reset clears all valid bits,
// not the store. A stalled response parks in a skid register; the pipeline holds without loss.
module image_resize_sampler_unit #(
	parameter int MAX_SRC_WIDTH  = irs_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = irs_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int MAX_PLANES     = irs_pkg::DEF_MAX_PLANES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	irs_req_if.sink                     req,
	irs_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irs_pkg::PADDR_W-1:0] paddr,
	input  logic [irs_pkg::PDATA_W-1:0] pwdata,
	output logic [irs_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int SRC_MAX = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
	localparam int QN      = $clog2(SRC_MAX) + irs_pkg::FRAC_W;
	localparam int PROD_W  = irs_pkg::TGT_CFG_W + irs_pkg::SRC_CFG_W;
	localparam int NW      = PROD_W + irs_pkg::FRAC_W - 1;
	localparam int CXW     = $clog2(MAX_SRC_WIDTH);
	localparam int CYW     = $clog2(MAX_SRC_HEIGHT);
	localparam int TIW     = QN + 1 - irs_pkg::FRAC_W;
	localparam int HALF    = 1 << (irs_pkg::FRAC_W - 1);

	irs_pkg::cfg_t cfg;
	logic          en, accept, in_err;

	logic              v_s1, v_s2, v_s3, v_s4;
	irs_pkg::tag_t     tag_s1, tag_s2, tag_s3;
	logic [PROD_W-1:0] px_s2, py_s2;
	logic              zero_s4, err_s4;
	logic [irs_pkg::FRAC_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;
	logic [CXW-1:0]    cxlo_s3, cxhi_s3;
	logic [CYW-1:0]    cylo_s3, cyhi_s3;

	logic              div_v;
	irs_pkg::tag_t     div_tag;
	logic [QN-1:0]     qx, qy;
	logic [QN:0]       tx, ty;
	logic [31:0]       tix, tiy, limx, limy;

	logic              st_we;
	logic [irs_pkg::SAMPLE_W-1:0] v00, v10, v01, v11;

	logic              bl_v;
	irs_pkg::rsp_t     bl_rsp;
	logic              out_v_q, skid_v_q;
	irs_pkg::rsp_t     out_q, skid_q;

	function automatic logic [31:0] axis_lo(logic [31:0] ti, logic [31:0] lim);
		logic [31:0] v;
		v = (ti == 32'd0) ? 32'd0 : ti - 32'd1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [31:0] axis_hi(logic [31:0] ti, logic [31:0] lim);
		return (ti > lim) ? lim : ti;
	endfunction

	irs_cfg_regs #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign en        = !skid_v_q;
	assign req.ready = en;
	assign accept    = req.valid & en;

	always_comb begin
		if (req.data.opcode == irs_pkg::OP_LOAD) begin
			in_err = (req.data.column >= irs_pkg::COORD_W'(cfg.src_w)) ||
			         (req.data.row >= irs_pkg::COORD_W'(cfg.src_h));
		end else begin
			in_err = ({1'b0, req.data.column} >= cfg.tgt_w) ||
			         ({1'b0, req.data.row} >= cfg.tgt_h);
		end
		if (32'(req.data.plane) >= MAX_PLANES) begin
			in_err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= div_v;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.opcode      <= req.data.opcode;
			tag_s1.range_error <= in_err;
			tag_s1.column      <= req.data.column;
			tag_s1.row         <= req.data.row;
			tag_s1.plane       <= req.data.plane;
			tag_s1.sample      <= req.data.sample_in;
			tag_s2 <= tag_s1;
			px_s2  <= PROD_W'({tag_s1.column, 1'b1}) * PROD_W'(cfg.src_w);
			py_s2  <= PROD_W'({tag_s1.row, 1'b1}) * PROD_W'(cfg.src_h);
		end
	end

	irs_coord_div #(
		.QN(QN),
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.in_tag   (tag_s2),
		.num_x    ({px_s2, (irs_pkg::FRAC_W-1)'(0)}),
		.num_y    ({py_s2, (irs_pkg::FRAC_W-1)'(0)}),
		.den_x    (cfg.tgt_w),
		.den_y    (cfg.tgt_h),
		.out_valid(div_v),
		.out_tag  (div_tag),
		.quo_x    (qx),
		.quo_y    (qy)
	);

	always_comb begin
		if (cfg.mode == irs_pkg::MODE_BILINEAR) begin
			tx = {1'b0, qx} + (QN+1)'(HALF);
			ty = {1'b0, qy} + (QN+1)'(HALF);
		end else begin
			tx = {TIW'(qx[QN-1:irs_pkg::FRAC_W]) + TIW'(1), irs_pkg::FRAC_W'(0)};
			ty = {TIW'(qy[QN-1:irs_pkg::FRAC_W]) + TIW'(1), irs_pkg::FRAC_W'(0)};
		end
		tix  = 32'(tx[QN:irs_pkg::FRAC_W]);
		tiy  = 32'(ty[QN:irs_pkg::FRAC_W]);
		limx = 32'(cfg.src_w) - 32'd1;
		limy = 32'(cfg.src_h) - 32'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3  <= div_tag;
			fx_s3   <= tx[irs_pkg::FRAC_W-1:0];
			fy_s3   <= ty[irs_pkg::FRAC_W-1:0];
			cxlo_s3 <= CXW'(axis_lo(tix, limx));
			cxhi_s3 <= CXW'(axis_hi(tix, limx));
			cylo_s3 <= CYW'(axis_lo(tiy, limy));
			cyhi_s3 <= CYW'(axis_hi(tiy, limy));
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			err_s4  <= tag_s3.range_error;
			zero_s4 <= tag_s3.range_error || (tag_s3.opcode == irs_pkg::OP_LOAD);
		end
	end

	assign st_we = en && v_s3 && (tag_s3.opcode == irs_pkg::OP_LOAD) && !tag_s3.range_error;

	irs_sample_store #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
		.MAX_PLANES    (MAX_PLANES),
		.CXW           (CXW),
		.CYW           (CYW)
	) u_store (
		.clk     (clk),
		.en      (en),
		.wr_en   (st_we),
		.wr_x    (CXW'(tag_s3.column)),
		.wr_y    (CYW'(tag_s3.row)),
		.wr_plane(tag_s3.plane),
		.wr_data (tag_s3.sample),
		.rd_x_lo (cxlo_s3),
		.rd_x_hi (cxhi_s3),
		.rd_y_lo (cylo_s3),
		.rd_y_hi (cyhi_s3),
		.rd_plane(tag_s3.plane),
		.v00     (v00),
		.v10     (v10),
		.v01     (v01),
		.v11     (v11)
	);

	irs_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_zero  (zero_s4),
		.in_err   (err_s4),
		.v00      (v00),
		.v10      (v10),
		.v01      (v01),
		.v11      (v11),
		.fx       (fx_s4),
		.fy       (fy_s4),
		.out_valid(bl_v),
		.out_rsp  (bl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (rsp.ready || !out_v_q) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= bl_v;
			end
		end else if (bl_v && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : bl_rsp;
		end else if (bl_v && en) begin
			skid_q <= bl_rsp;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a response while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !rsp.ready))
		else $error("skid register filled without a stalled output");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.range_error) |-> (rsp.data.sample_out == '0))
		else $error("flagged response carries a nonzero sample");

endmodule
